FILE: hw/rtl/ifr_pkg.sv
// Shared types and constants for the information frame receiver.
`default_nettype none
package ifr_pkg;

   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] RR_CODE    = 8'h05;
   localparam logic [7:0] REJ_CODE   = 8'h01;
   localparam logic [7:0] REPLY_ADDR = 8'h03;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_FLAG  = 2'd1,
      PH_FRAME = 2'd2
   } phase_type;

   typedef enum logic {
      TOK_DATA  = 1'b0,
      TOK_CLOSE = 1'b1
   } tok_kind_type;

   // One classified event passed from the front end to the frame logic.
   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;
      logic         esc;
   } token_type;

   typedef enum logic {
      RES_BYTE    = 1'b0,
      RES_VERDICT = 1'b1
   } res_kind_type;

   typedef struct packed {
      res_kind_type kind;
      logic [7:0]   payload_byte;
      logic         accepted;
      logic [7:0]   reply_control;
      logic [7:0]   reply_check;
   } result_type;

endpackage
`default_nettype wire

FILE: hw/rtl/ifr_front.sv
// Front end: flag hunting and escape removal, one token per useful byte.
`default_nettype none
module ifr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [7:0]         in_byte,
   input  wire logic               tok_ready,
   output logic                    in_ready,
   output logic                    tok_valid,
   output ifr_pkg::token_type      tok
);
   import ifr_pkg::*;

   phase_type phase_ff, phase_in;
   logic      esc_ff, esc_in;
   logic      take;
   logic      is_flag;

   assign in_ready = tok_ready;
   assign take     = in_valid && tok_ready;
   assign is_flag  = (in_byte == FLAG_BYTE);

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      if (take) begin
         unique case (phase_ff)
            PH_FLAG, PH_FRAME: begin
               if (is_flag) begin
                  phase_in = (phase_ff == PH_FLAG) ? PH_FLAG : PH_HUNT;
                  esc_in   = 1'b0;
               end else begin
                  phase_in = PH_FRAME;
                  esc_in   = esc_ff ? 1'b0 : (in_byte == ESC_BYTE);
               end
            end
            default: begin
               esc_in = 1'b0;
               if (is_flag) begin
                  phase_in = PH_FLAG;
               end
            end
         endcase
      end
   end

   // Token outputs.
   always_comb begin
      tok_valid = 1'b0;
      tok.kind  = TOK_DATA;
      tok.data  = in_byte;
      tok.esc   = esc_ff;
      unique case (phase_ff)
         PH_FRAME: begin
            if (is_flag) begin
               tok_valid = in_valid;
               tok.kind  = TOK_CLOSE;
            end else if (esc_ff) begin
               tok_valid = in_valid;
               tok.data  = in_byte ^ ESC_XOR;
            end else begin
               tok_valid = in_valid && (in_byte != ESC_BYTE);
            end
         end
         PH_FLAG: begin
            // A flag right after a flag restarts the frame, which is already clear.
            if (!is_flag) begin
               tok_valid = in_valid && (in_byte != ESC_BYTE);
            end
         end
         default: begin
            tok_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         esc_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/ifr_queue.sv
// Short token queue between the front end and the frame logic.
`default_nettype none
module ifr_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire ifr_pkg::token_type push_tok,
   output logic                    push_ready,
   output logic                    pop_valid,
   output ifr_pkg::token_type      pop_tok,
   input  wire logic               pop_ready
);
   import ifr_pkg::*;

   token_type           mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_tok    = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/ifr_back.sv
// Frame logic: header capture, delayed payload forwarding, checks and reply.
`default_nettype none
module ifr_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               tok_valid,
   input  wire ifr_pkg::token_type tok,
   output logic                    tok_ready,
   output logic                    res_valid,
   output ifr_pkg::result_type     res,
   input  wire logic               res_ready
);
   import ifr_pkg::*;

   logic [1:0]  hcount_ff, hcount_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic        hgood_ff, hgood_in;
   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  xor_ff, xor_in;
   logic        seq_ff, seq_in;
   logic        res_valid_ff, res_valid_in;
   result_type  res_ff, res_in;
   logic        take;
   logic        emit;
   logic        acc;
   logic [7:0]  rc;
   logic [7:0]  expect_ctrl;

   assign tok_ready = !res_valid_ff || res_ready;
   assign take      = tok_valid && tok_ready;
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   assign expect_ctrl = {1'b0, ~seq_ff, 6'b0};
   assign acc = (hcount_ff == 2'd3) && hgood_ff && held_valid_ff &&
                (held_ff == xor_ff) && !tok.esc;
   assign rc  = {seq_ff, 7'b0} | (acc ? RR_CODE : REJ_CODE);

   always_comb begin
      hcount_in     = hcount_ff;
      addr_in       = addr_ff;
      ctrl_in       = ctrl_ff;
      hgood_in      = hgood_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      xor_in        = xor_ff;
      seq_in        = seq_ff;
      emit          = 1'b0;
      res_in        = '0;
      if (take) begin
         unique case (tok.kind)
            TOK_CLOSE: begin
               emit                 = 1'b1;
               res_in.kind          = RES_VERDICT;
               res_in.accepted      = acc;
               res_in.reply_control = rc;
               res_in.reply_check   = REPLY_ADDR ^ rc;
               if (acc) begin
                  seq_in = ~seq_ff;
               end
               hcount_in     = '0;
               addr_in       = '0;
               ctrl_in       = '0;
               hgood_in      = 1'b0;
               held_in       = '0;
               held_valid_in = 1'b0;
               xor_in        = '0;
            end
            default: begin
               unique case (hcount_ff)
                  2'd0: begin
                     addr_in   = tok.data;
                     hcount_in = 2'd1;
                  end
                  2'd1: begin
                     ctrl_in   = tok.data;
                     hcount_in = 2'd2;
                  end
                  2'd2: begin
                     hgood_in  = ((addr_ff ^ ctrl_ff) == tok.data) &&
                                 (ctrl_ff == expect_ctrl);
                     hcount_in = 2'd3;
                  end
                  default: begin
                     // Payload goes out one byte late so the check byte stays behind.
                     if (held_valid_ff) begin
                        emit                = 1'b1;
                        res_in.kind         = RES_BYTE;
                        res_in.payload_byte = held_ff;
                        xor_in              = xor_ff ^ held_ff;
                     end
                     held_in       = tok.data;
                     held_valid_in = 1'b1;
                  end
               endcase
            end
         endcase
      end
      if (emit) begin
         res_valid_in = 1'b1;
      end else if (res_ready) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcount_ff     <= '0;
         addr_ff       <= '0;
         ctrl_ff       <= '0;
         hgood_ff      <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         xor_ff        <= '0;
         seq_ff        <= 1'b1;
         res_valid_ff  <= 1'b0;
      end else begin
         hcount_ff     <= hcount_in;
         addr_ff       <= addr_in;
         ctrl_ff       <= ctrl_in;
         hgood_ff      <= hgood_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         xor_ff        <= xor_in;
         seq_ff        <= seq_in;
         res_valid_ff  <= res_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/info_frame_receiver.sv
// Top level of the byte-stuffed information frame receiver.
//
// The req_ channel takes one raw line byte per beat. The front end hunts for
// the 0x7E flag and strips escape pairs, then hands data and closing-flag
// tokens through a four-entry queue to the frame logic. The rsp_ channel
// carries one beat per forwarded payload byte (tuser 0) and one verdict beat
// per closing flag (tuser 1) with the RR or REJ reply.
// Throughput is one byte per cycle while rsp_tready is high: the front end
// and the frame logic each handle one token a cycle, and a result sits in a
// single output register. The token for an accepted byte is written into
// the queue, and the frame logic then loads any result into the output
// register; earlier queued tokens or a stalled rsp_ can hold it back.
// When the receiver holds rsp_tready low, the output register holds its beat,
// the queue fills, and req_tready drops once four tokens are waiting.
// Reset is synchronous; it empties the queue, returns to flag hunting, clears
// the frame state and sets the receive sequence bit so that the first
// expected control byte is 0x00.
`default_nettype none
module info_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte [7:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // payload_byte [7:0], accepted [8], reply_control [16:9],
   // reply_check [24:17], zero [31:25]
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tuser    // kind [0]
);
   import ifr_pkg::*;

   logic       f_tok_valid;
   token_type  f_tok;
   logic       f_tok_ready;
   logic       q_valid;
   token_type  q_tok;
   logic       q_ready;
   result_type res;

   ifr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .tok_ready (f_tok_ready),
      .in_ready  (req_tready),
      .tok_valid (f_tok_valid),
      .tok       (f_tok)
   );

   ifr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_tok_valid),
      .push_tok   (f_tok),
      .push_ready (f_tok_ready),
      .pop_valid  (q_valid),
      .pop_tok    (q_tok),
      .pop_ready  (q_ready)
   );

   ifr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_valid),
      .tok       (q_tok),
      .tok_ready (q_ready),
      .res_valid (rsp_tvalid),
      .res       (res),
      .res_ready (rsp_tready)
   );

   assign rsp_tuser = res.kind;
   assign rsp_tdata = {7'b0, res.reply_check, res.reply_control, res.accepted,
                       res.payload_byte};

endmodule
`default_nettype wire

FILE: dv/info_frame_receiver_tb.sv
// Self-checking testbench for the info frame receiver: stuffed frames in, beats scored.
`timescale 1ns / 1ps
module info_frame_receiver_tb;
   import ifr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 64;
   localparam int DRAIN_CYCLES = 10;

   typedef enum {
      FL_NONE,      // well-formed frame with the expected sequence value
      FL_HCS,       // header check corrupted
      FL_SEQ,       // control byte not the expected sequence value
      FL_CHK,       // payload check corrupted
      FL_SHORT,     // frame closes inside or right after the header
      FL_ESC_END    // escape byte right before the closing flag
   } frame_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // rx_byte [7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // payload_byte [7:0], accepted [8],
                                    // reply_control [16:9], reply_check [24:17]
   logic        rsp_tuser;          // kind [0]

   info_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [7:0] pending_bytes[$];
   result_type expected_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int queued_bytes  = 0;
   int frames_built  = 0;
   int bytes_sent    = 0;
   int beat_index    = 0;
   int payload_seen  = 0;
   int rr_seen       = 0;
   int rej_seen      = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   logic hold_request = 1'b0;
   logic hold_served  = 1'b0;

   // Sequence bit that the stimulus side believes the receiver expects next.
   logic gen_seq = 1'b0;

   // Deframer prediction state.
   phase_type  rx_phase;
   logic [1:0] hdr_count;
   logic [7:0] addr_byte;
   logic [7:0] ctrl_byte;
   logic       hdr_ok;
   logic       esc_armed;
   logic [7:0] pend_byte;
   logic       pend_valid;
   logic [7:0] payload_xor;
   logic       rx_seq;

   task automatic drop_frame();
      hdr_count   = '0;
      addr_byte   = '0;
      ctrl_byte   = '0;
      hdr_ok      = 1'b0;
      esc_armed   = 1'b0;
      pend_byte   = '0;
      pend_valid  = 1'b0;
      payload_xor = '0;
   endtask

   // Advances the deframer by one line byte and queues any beat it causes.
   task automatic deframe_byte(input logic [7:0] b);
      result_type r;
      logic [7:0] d;
      logic       have_d;
      logic       good;
      r = '0;
      have_d = 1'b0;
      d = b;
      if (rx_phase != PH_FLAG && rx_phase != PH_FRAME) begin
         if (b == FLAG_BYTE) begin
            drop_frame();
            rx_phase = PH_FLAG;
         end
      end else if (b == FLAG_BYTE) begin
         if (rx_phase == PH_FLAG) begin
            drop_frame();
         end else begin
            good = (hdr_count == 2'd3) && hdr_ok && pend_valid &&
                   (pend_byte == payload_xor) && !esc_armed;
            r.kind          = RES_VERDICT;
            r.accepted      = good;
            r.reply_control = {rx_seq, 7'd0} | (good ? RR_CODE : REJ_CODE);
            r.reply_check   = REPLY_ADDR ^ r.reply_control;
            expected_results.push_back(r);
            if (good) rx_seq = !rx_seq;
            drop_frame();
            // The closing flag does not open the next frame.
            rx_phase = PH_HUNT;
         end
      end else begin
         rx_phase = PH_FRAME;
         if (esc_armed) begin
            d = b ^ ESC_XOR;
            esc_armed = 1'b0;
            have_d = 1'b1;
         end else if (b == ESC_BYTE) begin
            esc_armed = 1'b1;
         end else begin
            have_d = 1'b1;
         end
      end
      if (have_d) begin
         case (hdr_count)
            2'd0: begin
               addr_byte = d;
               hdr_count = 2'd1;
            end
            2'd1: begin
               ctrl_byte = d;
               hdr_count = 2'd2;
            end
            2'd2: begin
               hdr_ok = ((addr_byte ^ ctrl_byte) == d) &&
                        (ctrl_byte == {1'b0, !rx_seq, 6'd0});
               hdr_count = 2'd3;
            end
            default: begin
               // Payload goes out one byte late, so the check byte never leaves.
               if (pend_valid) begin
                  r.kind         = RES_BYTE;
                  r.payload_byte = pend_byte;
                  expected_results.push_back(r);
                  payload_xor = payload_xor ^ pend_byte;
               end
               pend_byte  = d;
               pend_valid = 1'b1;
            end
         endcase
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      queued_bytes++;
   endtask

   // Escapes flag and escape bytes, and now and then a byte that needs no escape.
   task automatic push_stuffed(input logic [7:0] b);
      if (b == FLAG_BYTE || b == ESC_BYTE ||
          ((b ^ ESC_XOR) != FLAG_BYTE && $urandom_range(15) == 0)) begin
         push_byte(ESC_BYTE);
         push_byte(b ^ ESC_XOR);
      end else begin
         push_byte(b);
      end
   endtask

   task automatic send_frame(input int pay_len, input frame_flaw_type flaw);
      logic [7:0] body[$];
      logic [7:0] want_ctrl;
      logic [7:0] ctrl;
      logic [7:0] hcs;
      logic [7:0] chk;
      logic [7:0] b;
      int         emit_len;
      want_ctrl = {1'b0, gen_seq, 6'd0};
      ctrl = want_ctrl;
      if (flaw == FL_SEQ) begin
         if ($urandom_range(1) == 0) begin
            ctrl = want_ctrl ^ 8'h40;
         end else begin
            do ctrl = 8'($urandom_range(255)); while (ctrl == want_ctrl);
         end
      end
      body.push_back(8'($urandom_range(255)));
      body.push_back(ctrl);
      hcs = body[0] ^ ctrl;
      if (flaw == FL_HCS) hcs = hcs ^ (8'h01 << $urandom_range(7));
      body.push_back(hcs);
      chk = '0;
      repeat (pay_len) begin
         b = 8'($urandom_range(255));
         chk = chk ^ b;
         body.push_back(b);
      end
      if (flaw == FL_CHK) chk = chk ^ (8'h01 << $urandom_range(7));
      body.push_back(chk);
      emit_len = (flaw == FL_SHORT) ? $urandom_range(1, 3) : body.size();
      push_byte(FLAG_BYTE);
      for (int i = 0; i < emit_len; i++) push_stuffed(body[i]);
      if (flaw == FL_ESC_END) push_byte(ESC_BYTE);
      push_byte(FLAG_BYTE);
      if (flaw == FL_NONE) gen_seq = !gen_seq;
      frames_built++;
   endtask

   // Queues line traffic: noise while hunting, repeated flags, then mostly good frames.
   task automatic queue_random(input int n);
      int         stop;
      int         pick;
      int         len;
      logic [7:0] b;
      stop = queued_bytes + n;
      while (queued_bytes < stop) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 4)) begin
               do b = 8'($urandom_range(255)); while (b == FLAG_BYTE);
               push_byte(b);
            end
         end
         if ($urandom_range(99) < 10) repeat ($urandom_range(1, 3)) push_byte(FLAG_BYTE);
         len = ($urandom_range(9) == 0) ? $urandom_range(11, 48) : $urandom_range(10);
         pick = $urandom_range(99);
         if (pick < 55)      send_frame(len, FL_NONE);
         else if (pick < 62) send_frame(len, FL_HCS);
         else if (pick < 69) send_frame(len, FL_SEQ);
         else if (pick < 76) send_frame(len, FL_CHK);
         else if (pick < 84) send_frame(len, FL_SHORT);
         else if (pick < 90) send_frame(len, FL_ESC_END);
         else begin
            // Unstructured frame body; almost certainly rejected.
            push_byte(FLAG_BYTE);
            repeat ($urandom_range(1, 12)) begin
               do b = 8'($urandom_range(255)); while (b == FLAG_BYTE);
               push_byte(b);
            end
            push_byte(FLAG_BYTE);
            frames_built++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("Mismatch on rsp beat %0d, %s: got %02h, expected %02h",
               beat_index, what, got, want);
      error_count++;
   endtask

   // Line byte driver; the deframer prediction runs on each accepted beat.
   always @(posedge clock) begin
      logic       next_valid;
      logic [7:0] next_data;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         rx_phase = PH_HUNT;
         rx_seq   = 1'b1;
         drop_frame();
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            bytes_sent++;
         end
         next_valid = req_tvalid && !req_tready;
         next_data  = req_tdata;
         if (!next_valid && pending_bytes.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_valid = 1'b1;
            next_data  = pending_bytes.pop_front();
         end
         req_tvalid <= next_valid;
         req_tdata  <= next_data;
      end
   end

   // Result monitor and scoreboard.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("beat with nothing expected, payload byte",
                               rsp_tdata[7:0], 8'h00);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", {7'd0, rsp_tuser}, {7'd0, want.kind});
               if (rsp_tdata[7:0] !== want.payload_byte)
                  report_mismatch("payload_byte", rsp_tdata[7:0], want.payload_byte);
               if (rsp_tdata[8] !== want.accepted)
                  report_mismatch("accepted", {7'd0, rsp_tdata[8]}, {7'd0, want.accepted});
               if (rsp_tdata[16:9] !== want.reply_control)
                  report_mismatch("reply_control", rsp_tdata[16:9], want.reply_control);
               if (rsp_tdata[24:17] !== want.reply_check)
                  report_mismatch("reply_check", rsp_tdata[24:17], want.reply_check);
               if (want.kind == RES_BYTE) payload_seen++;
               else if (want.accepted) rr_seen++;
               else rej_seen++;
            end
            beat_index++;
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off, counted here once the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_request && !hold_served) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 36;
      recv_idle_pct = 73;
      // Back-to-back flags, then a good frame carrying a flag and an escape byte.
      push_byte(FLAG_BYTE); push_byte(FLAG_BYTE);
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
      push_byte(ESC_BYTE); push_byte(8'h5E); push_byte(ESC_BYTE); push_byte(8'h5D);
      push_byte(8'h03); push_byte(FLAG_BYTE);
      // Frame that closes inside the header.
      push_byte(FLAG_BYTE); push_byte(8'h03); push_byte(FLAG_BYTE);
      // Escape left pending at the closing flag.
      push_byte(FLAG_BYTE); push_byte(ESC_BYTE); push_byte(FLAG_BYTE);
      // Right sequence value, wrong payload check.
      push_byte(FLAG_BYTE); push_byte(8'h00); push_byte(8'h40); push_byte(8'h40);
      push_byte(8'hAA); push_byte(8'h00); push_byte(FLAG_BYTE);
      gen_seq = 1'b1;
      queue_random(600);

      for (int p = 1; p < 3; p++) begin
         // The sender stops here until every expected result has arrived.
         while (pending_bytes.size() != 0 || req_tvalid) @(negedge clock);
         while (expected_results.size() != 0) @(negedge clock);
         if (p == 1) begin
            send_idle_pct = 73;
            recv_idle_pct = 36;
            queue_random(640);
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            queue_random(640);
            hold_request = 1'b1;
         end
      end

      while (pending_bytes.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d line bytes in %0d frames under three stall mixes and a %0d-cycle hold.",
               bytes_sent, frames_built, HOLD_CYCLES);
      $display("Checked %0d payload beats and %0d verdicts (%0d RR, %0d REJ).",
               payload_seen, rr_seen + rej_seen, rr_seen, rej_seen);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
